// ===== rtl/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types and character constants for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

  typedef enum logic [1:0] {
    CMD_DEC    = 2'd0,
    CMD_PTR    = 2'd1,
    CMD_HEX_LO = 2'd2,
    CMD_HEX_UP = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } txt_t;

  // Control shared by every digit cell of the chain.
  typedef struct packed {
    logic clear;
    logic conv;
    logic emit;
    logic dec;
  } cell_ctl_t;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_MINUS   = 8'h2d;
  localparam logic [7:0] ASCII_X       = 8'h78;
  localparam logic [3:0] DIGIT_TEN     = 4'd10;

  // Maps one digit (decimal or hex) to its ASCII code.
  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] d8;
    d8 = {4'h0, d};
    if (d < DIGIT_TEN) begin
      digit_char = ASCII_ZERO + d8;
    end else if (upper) begin
      digit_char = ASCII_UPPER_A + d8 - {4'h0, DIGIT_TEN};
    end else begin
      digit_char = ASCII_LOWER_A + d8 - {4'h0, DIGIT_TEN};
    end
  endfunction

endpackage

// ===== rtl/ita_cell.sv =====
// ----------------------------------------------------------------------------
// ita_cell
// One 4-bit digit cell of the conversion chain: shift-and-add-3 step for
// decimal, plain shift for hex, and a digit-wide shift for readout.
// ----------------------------------------------------------------------------
module ita_cell (
  input  logic                 clk,
  input  ita_pkg::cell_ctl_t   ctl,
  input  logic                 carry_in,
  input  logic [3:0]           digit_in,
  output logic                 carry_out,
  output logic [3:0]           digit
);

  logic [3:0] adj;

  // A decimal digit of five or more is corrected before it is doubled.
  always_comb begin
    adj = digit;
    if (ctl.dec && (digit >= 4'd5)) begin
      adj = digit + 4'd3;
    end
  end

  assign carry_out = adj[3];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= 4'd0;
    end else if (ctl.conv) begin
      digit <= {adj[2:0], carry_in};
    end else if (ctl.emit) begin
      digit <= digit_in;
    end
  end

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Turns a command and a value into its ASCII text, one character per item.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                        | Direction | Item
//   --------+--------------------------------+-----------+-------------------------
//   req     | req_valid, req_ready, req      | in        | command and value
//   txt     | txt_valid, txt_ready, txt      | out       | one character, last flag
//
// An accepted request first shifts its magnitude, one bit per cycle, through
// the chain of digit cells. Readout then hands out the prefix characters and
// then the digit of each cell (NCELL cells, 20 at 64 bits), where leading
// zero digits are dropped without producing an item.
// Reset clears the control state and the output valid flag; the cells need none.
// A stalled output holds the chain, and a new request is taken once the last
// character has been handed to the output register.
//
module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ita_pkg::req_t  req,
  output logic           txt_valid,
  input  logic           txt_ready,
  output ita_pkg::txt_t  txt
);

  // Enough decimal digits for a magnitude of up to 2**(VALUE_WIDTH-1), and
  // enough nibbles for the widest hex value; the chain covers both.
  localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NHEX  = (VALUE_WIDTH + 3) / 4;
  localparam int NCELL = (NDIG > NHEX) ? NDIG : NHEX;
  localparam int CW    = $clog2(VALUE_WIDTH + 1);
  localparam int RW    = $clog2(NCELL + 1);

  // The plain hex commands only look at the low 32 bits.
  localparam logic [VALUE_WIDTH-1:0] HEX_MASK = VALUE_WIDTH'(64'h0000_0000_FFFF_FFFF);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                  state;
  logic [VALUE_WIDTH-1:0]  sh;
  logic [CW-1:0]           cnt;
  logic [RW-1:0]           rem;
  logic [1:0]              pre_cnt;
  logic                    seen;
  logic                    is_dec;
  logic                    is_ptr;
  logic                    upper;

  ita_pkg::cell_ctl_t      ctl;
  logic                    accept;
  logic                    slot_free;
  logic                    out_load;
  logic [7:0]              out_char;
  logic                    out_last;
  logic                    rem_one;

  logic [VALUE_WIDTH-1:0]  in_val;
  logic                    in_neg;
  logic [VALUE_WIDTH-1:0]  in_mag;

  logic [3:0]              dig   [NCELL];
  logic                    carry [NCELL];
  logic [3:0]              top;

  // --------------------------------------------------------------------------
  // Chain of digit cells. Cell 0 takes the next magnitude bit during
  // conversion; during readout each cell passes its digit one place up and
  // the top cell's digit is the one printed.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic       cin;
    logic [3:0] din;
    if (i == 0) begin : g_first
      assign cin = sh[VALUE_WIDTH-1];
      assign din = 4'd0;
    end else begin : g_rest
      assign cin = carry[i-1];
      assign din = dig[i-1];
    end
    ita_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .carry_in  (cin),
      .digit_in  (din),
      .carry_out (carry[i]),
      .digit     (dig[i])
    );
  end

  assign top       = dig[NCELL-1];
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !txt_valid || txt_ready;
  assign rem_one   = (rem == RW'(1));

  // Input decode: a negative decimal value is replaced by its magnitude, which
  // fits in VALUE_WIDTH bits even for the most negative value.
  always_comb begin
    in_val = req.value[VALUE_WIDTH-1:0];
    in_neg = (req.command == ita_pkg::CMD_DEC) && in_val[VALUE_WIDTH-1];
    if (in_neg) begin
      in_mag = (~in_val) + VALUE_WIDTH'(1);
    end else if ((req.command == ita_pkg::CMD_HEX_LO) ||
                 (req.command == ita_pkg::CMD_HEX_UP)) begin
      in_mag = in_val & HEX_MASK;
    end else begin
      in_mag = in_val;
    end
  end

  // Readout control. Prefix characters go first; then one digit per cycle while
  // the output slot is free, dropping leading zeros but always printing the lowest digit.
  always_comb begin
    ctl.clear = accept;
    ctl.conv  = (state == S_CONV);
    ctl.emit  = 1'b0;
    ctl.dec   = is_dec;
    out_load  = 1'b0;
    out_char  = 8'h00;
    out_last  = 1'b0;
    if ((state == S_EMIT) && slot_free) begin
      if (pre_cnt != 2'd0) begin
        out_load = 1'b1;
        if (is_ptr) begin
          out_char = (pre_cnt == 2'd2) ? ita_pkg::ASCII_ZERO : ita_pkg::ASCII_X;
        end else begin
          out_char = ita_pkg::ASCII_MINUS;
        end
      end else begin
        ctl.emit = 1'b1;
        if (seen || (top != 4'd0) || rem_one) begin
          out_load = 1'b1;
          out_char = ita_pkg::digit_char(top, upper);
          out_last = rem_one;
        end
      end
    end
  end

  // Sequencer and per-request registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (cnt == CW'(1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (ctl.emit && rem_one) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sh      <= in_mag;
      cnt     <= CW'(VALUE_WIDTH);
      rem     <= RW'(NCELL);
      seen    <= 1'b0;
      is_dec  <= (req.command == ita_pkg::CMD_DEC);
      is_ptr  <= (req.command == ita_pkg::CMD_PTR);
      upper   <= (req.command == ita_pkg::CMD_HEX_UP);
      if (req.command == ita_pkg::CMD_PTR) begin
        pre_cnt <= 2'd2;
      end else if (in_neg) begin
        pre_cnt <= 2'd1;
      end else begin
        pre_cnt <= 2'd0;
      end
    end else begin
      if (ctl.conv) begin
        sh  <= {sh[VALUE_WIDTH-2:0], 1'b0};
        cnt <= cnt - CW'(1);
      end
      if (ctl.emit) begin
        rem <= rem - RW'(1);
        if (out_load) begin
          seen <= 1'b1;
        end
      end
      if (out_load && (pre_cnt != 2'd0)) begin
        pre_cnt <= pre_cnt - 2'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      txt_valid <= 1'b0;
    end else if (out_load) begin
      txt_valid <= 1'b1;
    end else if (txt_ready) begin
      txt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      txt.character <= out_char;
      txt.last      <= out_last;
    end
  end

endmodule

// ===== rtl/ita_checker.sv =====
// ----------------------------------------------------------------------------
// ita_checker
// Port-level checks for the integer-to-ASCII formatter, bound to the top level.
// ----------------------------------------------------------------------------
module ita_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ita_pkg::req_t req,
  input logic          txt_valid,
  input logic          txt_ready,
  input ita_pkg::txt_t txt
);

  // Reset leaves no character pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !txt_valid)
    else $error("character pending after reset");

  // A request stays in work through conversion and readout, so the next one cannot follow at once.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted on two cycles in a row");

  // A stalled character holds.
  a_txt_hold: assert property (@(posedge clk) disable iff (rst)
    (txt_valid && !txt_ready) |=> (txt_valid && $stable(txt)))
    else $error("stalled character changed or vanished");

  // Every printed character is a digit, a hex letter, a minus or an x.
  a_txt_charset: assert property (@(posedge clk) disable iff (rst)
    txt_valid |->
      ((txt.character >= 8'h30) && (txt.character <= 8'h39)) ||
      ((txt.character >= 8'h61) && (txt.character <= 8'h66)) ||
      ((txt.character >= 8'h41) && (txt.character <= 8'h46)) ||
      (txt.character == 8'h2d) || (txt.character == 8'h78))
    else $error("character outside the output alphabet");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .txt_valid (txt_valid),
  .txt_ready (txt_ready),
  .txt       (txt)
);

// ===== bench/tb_integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// Self-checking bench for the integer-to-ASCII formatter. Requests are driven
// over the req channel with random gaps. The expected text of each accepted
// request is computed here and queued one character at a time. Every character
// that leaves the txt channel is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is stopped if it goes past this many cycles. The slowest correct
  // run stays far below it: about 220 requests of at most 20 characters, each
  // character subject to random stall bursts, plus one long hold-off.
  localparam int CYCLE_LIMIT     = 1_000_000;
  // Length of the long output hold-off that makes the block stall its input.
  localparam int HOLD_OFF_CYCLES = 400;
  // Quiet cycles after the last expected character, so that any extra
  // character from the block is still caught.
  localparam int DRAIN_CYCLES    = 200;

  // Digit tables, first character in the top byte.
  localparam logic [8*10-1:0] DEC_DIGITS = "0123456789";
  localparam logic [8*16-1:0] HEX_LOWER  = "0123456789abcdef";
  localparam logic [8*16-1:0] HEX_UPPER  = "0123456789ABCDEF";

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  ita_pkg::req_t  req       = '0;
  logic           txt_valid;
  logic           txt_ready = 1'b0;
  ita_pkg::txt_t  txt;

  // Characters still owed by the block, oldest first.
  ita_pkg::txt_t  pending_text[$];
  int    error_count     = 0;
  int    cycle_count     = 0;
  // When set, both sides insert random idle bursts.
  bit    idling_on       = 1'b1;
  // Raised by a test to ask the output side for one long hold-off.
  bit    hold_off_wanted = 1'b0;

  integer_to_ascii_formatter #(
    .VALUE_WIDTH(64)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .txt_valid(txt_valid),
    .txt_ready(txt_ready),
    .txt      (txt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung block must not stall the run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Works out the text of one request and appends it, character by character,
  // to the queue of owed characters. Decimal reads the value as two's
  // complement, so the most negative value becomes its full magnitude after the
  // minus sign. The two plain hex commands look at the low 32 bits only.
  // Digits are produced least significant first and pushed to the front, which
  // leaves them in reading order and never prints a leading zero; zero itself
  // still yields one digit because the loop runs at least once.
  function automatic void predict_text(input ita_pkg::req_t item);
    logic [7:0]     chars[$];
    logic [7:0]     digits[$];
    logic [63:0]    magnitude;
    logic [63:0]    radix;
    logic [63:0]    remainder;
    logic [3:0]     digit;
    ita_pkg::txt_t  entry;
    radix     = 64'd16;
    magnitude = item.value;
    case (item.command)
      ita_pkg::CMD_DEC: begin
        radix = 64'd10;
        if (item.value[63]) begin
          chars.push_back(ita_pkg::ASCII_MINUS);
          magnitude = ~item.value + 64'd1;
        end
      end
      ita_pkg::CMD_PTR: begin
        chars.push_back(ita_pkg::ASCII_ZERO);
        chars.push_back(ita_pkg::ASCII_X);
      end
      default: begin
        magnitude = {32'h0, item.value[31:0]};
      end
    endcase
    do begin
      remainder = magnitude % radix;
      digit     = remainder[3:0];
      if (item.command == ita_pkg::CMD_DEC) begin
        digits.push_front(DEC_DIGITS[8*(9-digit) +: 8]);
      end else if (item.command == ita_pkg::CMD_HEX_UP) begin
        digits.push_front(HEX_UPPER[8*(15-digit) +: 8]);
      end else begin
        digits.push_front(HEX_LOWER[8*(15-digit) +: 8]);
      end
      magnitude = magnitude / radix;
    end while (magnitude != 64'd0);
    foreach (digits[i]) chars.push_back(digits[i]);
    foreach (chars[i]) begin
      entry.character = chars[i];
      entry.last      = (i == chars.size() - 1);
      pending_text.push_back(entry);
    end
  endfunction

  // Result checker. Outputs are sampled at the rising edge, before the block's
  // own updates of that edge take effect, and compared field by field with the
  // oldest owed character.
  always @(posedge clk) begin
    ita_pkg::txt_t owed;
    if (!rst && txt_valid && txt_ready) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                 $time, txt.character, txt.last);
        error_count++;
      end else begin
        owed = pending_text.pop_front();
        if (txt.character !== owed.character) begin
          $display("%0t: character mismatch: expected 0x%02h, actual 0x%02h",
                   $time, owed.character, txt.character);
          error_count++;
        end
        if (txt.last !== owed.last) begin
          $display("%0t: last flag mismatch: expected %0b, actual %0b",
                   $time, owed.last, txt.last);
          error_count++;
        end
      end
    end
  end

  // Output side. Ready changes only at the falling edge. A stall counter in
  // this process covers both the short random bursts and the long hold-off a
  // test may ask for, so ready gets exactly one assignment per edge.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        txt_ready <= 1'b0;
      end else if (hold_off_wanted) begin
        hold_off_wanted = 1'b0;
        stall_left      = HOLD_OFF_CYCLES - 1;
        txt_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        txt_ready <= 1'b0;
      end else begin
        txt_ready <= 1'b1;
      end
    end
  end

  // Offers one request and returns at the falling edge after it was taken.
  // Valid is only lowered for an idle burst, so back-to-back requests keep it
  // high without a dip. The expected text is queued at the accepting edge.
  task automatic send_request(input ita_pkg::req_t item);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_text(item);
    @(negedge clk);
  endtask

  task automatic send_command(input ita_pkg::cmd_t command, input logic [63:0] value);
    ita_pkg::req_t item;
    item.command = command;
    item.value   = value;
    send_request(item);
  endtask

  // Random values shaped to reach every text length: full-width values, values
  // of a random bit length, negatives of random size, powers of ten and their
  // neighbors, and hex values with junk in the ignored upper half.
  function automatic logic [63:0] random_value();
    logic [63:0] full;
    logic [63:0] ten_power;
    int          bits;
    full      = {$urandom, $urandom};
    ten_power = 64'd1;
    case ($urandom_range(0, 4))
      0: return full;
      1: begin
        bits = $urandom_range(1, 64);
        return full & (~64'd0 >> (64 - bits));
      end
      2: begin
        bits = $urandom_range(1, 63);
        return ~(full & (~64'd0 >> (64 - bits))) + 64'd1;
      end
      3: begin
        repeat ($urandom_range(0, 19)) ten_power = ten_power * 64'd10;
        return ten_power + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: begin
        bits = $urandom_range(1, 32);
        return {$urandom, $urandom & (32'hffff_ffff >> (32 - bits))};
      end
    endcase
  endfunction

  task automatic send_random_requests(input int count);
    repeat (count) send_command(ita_pkg::cmd_t'($urandom_range(0, 3)), random_value());
  endtask

  // Extremes and the special cases: zero in every form, the most negative
  // value (20 characters), the largest positive value, all ones, and hex
  // values whose upper 32 bits must be ignored.
  task automatic test_directed_values();
    send_command(ita_pkg::CMD_DEC,    64'd0);
    send_command(ita_pkg::CMD_PTR,    64'd0);
    send_command(ita_pkg::CMD_HEX_LO, 64'd0);
    send_command(ita_pkg::CMD_HEX_UP, 64'd0);
    send_command(ita_pkg::CMD_DEC,    64'h8000_0000_0000_0000);
    send_command(ita_pkg::CMD_DEC,    64'h7fff_ffff_ffff_ffff);
    send_command(ita_pkg::CMD_DEC,    64'hffff_ffff_ffff_ffff);
    send_command(ita_pkg::CMD_DEC,    64'd9);
    send_command(ita_pkg::CMD_DEC,    64'd10);
    send_command(ita_pkg::CMD_DEC,    64'hffff_ffff_ffff_fff6);
    send_command(ita_pkg::CMD_PTR,    64'hffff_ffff_ffff_ffff);
    send_command(ita_pkg::CMD_PTR,    64'h8000_0000_0000_0000);
    send_command(ita_pkg::CMD_PTR,    64'h0123_4567_89ab_cdef);
    send_command(ita_pkg::CMD_HEX_LO, 64'hffff_ffff_ffff_ffff);
    send_command(ita_pkg::CMD_HEX_UP, 64'hffff_ffff_ffff_ffff);
    send_command(ita_pkg::CMD_HEX_LO, 64'h1234_5678_dead_beef);
    send_command(ita_pkg::CMD_HEX_UP, 64'h8765_4321_dead_beef);
    send_command(ita_pkg::CMD_HEX_LO, 64'hffff_ffff_0000_0000);
    send_command(ita_pkg::CMD_HEX_UP, 64'hffff_ffff_0000_000a);
    send_command(ita_pkg::CMD_HEX_LO, 64'h0000_0000_0000_000f);
    send_command(ita_pkg::CMD_DEC,    64'd1);
  endtask

  // The bulk of the run: random commands and values with idling on both sides.
  task automatic test_random_values();
    send_random_requests(158);
  endtask

  // The output side stops for a long stretch while requests keep coming, so
  // the block fills up and must hold its input off until the text drains.
  task automatic test_output_hold_off();
    hold_off_wanted = 1'b1;
    send_command(ita_pkg::CMD_DEC, 64'h8000_0000_0000_0000);
    send_random_requests(11);
  endtask

  // Last part: no idling anywhere, requests and characters back to back.
  task automatic test_steady_stream();
    idling_on = 1'b0;
    send_random_requests(30);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_directed_values();
    test_random_values();
    test_output_hold_off();
    test_steady_stream();

    req_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
